### rtl/core/mse_pkg.sv
`timescale 1ns / 1ps
package mse_pkg;
	localparam int VALUE_W = 32;

	// one request passed from the front (loader) to the back (sorter)
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
	} mse_req_t;
endpackage

### rtl/core/mse_front.sv
`timescale 1ns / 1ps
// Input side: takes requests into a short queue for the sorter.
module mse_front import mse_pkg::*; #(
	parameter int QDEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  mse_req_t         in_req,
	output logic             q_valid,
	input  logic             q_ready,
	output mse_req_t         q_req
);
	localparam int QW = $clog2(QDEPTH);

	mse_req_t          fifo_q [QDEPTH];
	logic [QW-1:0]     wr_q, rd_q;
	logic [QW:0]       cnt_q;
	logic              push, pop;

	assign in_ready = (cnt_q != QDEPTH[QW:0]);
	assign q_valid  = (cnt_q != '0);
	assign q_req    = fifo_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QW'(QDEPTH-1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QW'(QDEPTH-1)) ? '0 : rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QW+1)'(push) - (QW+1)'(pop);
		end
	end
endmodule

### rtl/core/mse_back.sv
`timescale 1ns / 1ps
// Sorter: loads the run, merges bottom-up between two memories, streams out.
module mse_back import mse_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	output logic               q_ready,
	input  mse_req_t           q_req,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [VALUE_W-1:0] out_value,
	output logic               out_final,
	output logic               out_ovf
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = AW + 1;

	localparam logic [2:0] ST_LOAD  = 3'd0;
	localparam logic [2:0] ST_PASS  = 3'd1;
	localparam logic [2:0] ST_MERGE = 3'd2;
	localparam logic [2:0] ST_EMIT  = 3'd3;
	localparam logic [2:0] ST_WAIT  = 3'd4;

	logic [VALUE_W-1:0] mem0 [DEPTH];
	logic [VALUE_W-1:0] mem1 [DEPTH];

	logic [2:0]    state_q;
	logic [CW-1:0] n_q, width_q, lo_q, a_q, b_q, mid_q, hi_q, k_q;
	logic          src_q, ovf_q;
	// merge step: fetch phase then compare/write phase
	logic          phase_q;
	logic [VALUE_W-1:0] ra_q, rb_q;
	logic          take_a;

	assign q_ready = (state_q == ST_LOAD);

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && q_valid && n_q != CW'(DEPTH)) begin
			mem0[n_q[AW-1:0]] <= q_req.value;
		end
		if (state_q == ST_MERGE && phase_q) begin
			if (src_q) mem0[k_q[AW-1:0]] <= take_a ? ra_q : rb_q;
			else       mem1[k_q[AW-1:0]] <= take_a ? ra_q : rb_q;
		end
	end

	// registered reads from the source memory
	always_ff @(posedge clk) begin
		if (src_q) begin
			ra_q <= mem1[a_q[AW-1:0]];
			rb_q <= mem1[b_q[AW-1:0]];
		end else begin
			ra_q <= mem0[a_q[AW-1:0]];
			rb_q <= mem0[b_q[AW-1:0]];
		end
	end

	always_comb begin
		if (a_q >= mid_q)      take_a = 1'b0;
		else if (b_q >= hi_q)  take_a = 1'b1;
		else                   take_a = ($signed(ra_q) <= $signed(rb_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			n_q       <= '0;
			ovf_q     <= 1'b0;
			src_q     <= 1'b0;
			phase_q   <= 1'b0;
			width_q   <= '0;
			lo_q      <= '0;
			a_q       <= '0;
			b_q       <= '0;
			mid_q     <= '0;
			hi_q      <= '0;
			k_q       <= '0;
			out_valid <= 1'b0;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (q_valid) begin
						if (n_q != CW'(DEPTH)) n_q <= n_q + 1'b1;
						else                   ovf_q <= 1'b1;
						if (q_req.last) begin
							width_q <= CW'(1);
							src_q   <= 1'b0;
							state_q <= ST_PASS;
						end
					end
				end
				ST_PASS: begin
					// one pass per doubling; whole run copied every pass
					if (width_q >= n_q) begin
						k_q     <= '0;
						a_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						lo_q    <= '0;
						a_q     <= '0;
						b_q     <= (width_q > n_q) ? n_q : width_q;
						mid_q   <= (width_q > n_q) ? n_q : width_q;
						hi_q    <= ((width_q << 1) > n_q) ? n_q : (width_q << 1);
						k_q     <= '0;
						phase_q <= 1'b0;
						state_q <= ST_MERGE;
					end
				end
				ST_MERGE: begin
					if (!phase_q) begin
						phase_q <= 1'b1;
					end else begin
						phase_q <= 1'b0;
						if (take_a) a_q <= a_q + 1'b1;
						else        b_q <= b_q + 1'b1;
						k_q <= k_q + 1'b1;
						if (k_q + 1'b1 == hi_q) begin
							if (hi_q == n_q) begin
								src_q   <= ~src_q;
								width_q <= width_q << 1;
								state_q <= ST_PASS;
							end else begin
								lo_q  <= hi_q;
								a_q   <= hi_q;
								b_q   <= ((hi_q + width_q) > n_q) ? n_q : hi_q + width_q;
								mid_q <= ((hi_q + width_q) > n_q) ? n_q : hi_q + width_q;
								hi_q  <= ((hi_q + (width_q << 1)) > n_q) ?
									n_q : hi_q + (width_q << 1);
							end
						end
					end
				end
				ST_WAIT: begin
					// waits out the registered read before each output
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (!out_valid) begin
						out_value <= ra_q;
						out_final <= (k_q + 1'b1 == n_q);
						out_ovf   <= ovf_q;
						out_valid <= 1'b1;
						k_q       <= k_q + 1'b1;
						a_q       <= k_q + 1'b1;
					end else if (out_ready) begin
						out_valid <= 1'b0;
						if (out_final) begin
							n_q     <= '0;
							ovf_q   <= 1'b0;
							src_q   <= 1'b0;
							a_q     <= '0;
							state_q <= ST_LOAD;
						end else begin
							state_q <= ST_WAIT;
						end
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end
endmodule

### rtl/core/merge_sort_engine.sv
`timescale 1ns / 1ps
// Stable ascending sort of signed 32-bit runs. Values stream in on s_axis,
// tlast closing a run; up to DEPTH values are kept, extra values are dropped
// and every result of that run flags overflow in m_axis_tuser. Loading takes
// one request per cycle while the sorter is loading (a 4-entry queue decouples
// the input). The sort is bottom-up in ceil(log2(n)) passes, each a setup step
// then a memory fetch and a compare/write per element, plus a final check that
// the sort is done; results then stream out before the next run is loaded.
module merge_sort_engine import mse_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // value
	input  logic        s_axis_tlast,   // last
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // sorted_value
	output logic        m_axis_tlast,   // final_res
	output logic        m_axis_tuser    // overflow
);
	mse_req_t in_req, q_req;
	logic     q_valid, q_ready;

	assign in_req.value = s_axis_tdata;
	assign in_req.last  = s_axis_tlast;

	mse_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_req(in_req),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req)
	);

	mse_back #(.DEPTH(DEPTH)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_value(m_axis_tdata), .out_final(m_axis_tlast), .out_ovf(m_axis_tuser)
	);
endmodule

### tb/merge_sort_engine_tb.sv
`timescale 1ns / 1ps
module merge_sort_engine_tb;
	import mse_pkg::*;

	localparam int DEPTH = 64;

	int fail_cnt;

	task automatic flag_mismatch(string msg);
		$display("MISMATCH: %s", msg);
		fail_cnt++;
	endtask

	// Holds the run being loaded and the queue of sorted values still due.
	class sort_board;
		logic [31:0] run_vals[$];
		bit          run_ovf;
		logic [33:0] due[$];   // {overflow, final, value}

		// note one accepted request; a closing request sorts the run
		function void note_request(logic [31:0] v, logic lst);
			logic [31:0] buf_a[$];
			logic [31:0] tmp;
			int          j;
			if (run_vals.size() < DEPTH)
				run_vals.push_back(v);
			else
				run_ovf = 1;
			if (lst) begin
				buf_a = run_vals;
				// insertion sort, strictly greater moves: stable
				for (int i = 1; i < buf_a.size(); i++) begin
					tmp = buf_a[i];
					j = i - 1;
					while (j >= 0 && $signed(buf_a[j]) > $signed(tmp)) begin
						buf_a[j + 1] = buf_a[j];
						j--;
					end
					buf_a[j + 1] = tmp;
				end
				foreach (buf_a[i])
					due.push_back({run_ovf, 1'(i == buf_a.size() - 1), buf_a[i]});
				run_vals.delete();
				run_ovf = 0;
			end
		endfunction

		task check_result(logic [31:0] v, logic fin, logic ovf);
			logic [33:0] e;
			if (due.size() == 0) begin
				flag_mismatch($sformatf("unexpected result %h", v));
				return;
			end
			e = due.pop_front();
			if (v !== e[31:0])
				flag_mismatch($sformatf("value %h, want %h", v, e[31:0]));
			if (fin !== e[32])
				flag_mismatch($sformatf("tlast %b, want %b", fin, e[32]));
			if (ovf !== e[33])
				flag_mismatch($sformatf("overflow %b, want %b", ovf, e[33]));
		endtask
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        m_axis_tuser;

	sort_board board;

	merge_sort_engine #(.DEPTH(DEPTH)) DUT (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// send one request after a random gap
	task automatic send_request(logic [31:0] v, logic lst);
		int gap;
		gap = $urandom_range(0, 4);
		if (gap > 0) begin
			s_axis_tvalid <= 0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata  <= v;
		s_axis_tlast  <= lst;
		do @(posedge clk); while (!s_axis_tready);
		board.note_request(v, lst);
	endtask

	task automatic drain();
		s_axis_tvalid <= 0;
		while (board.due.size() != 0) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'($urandom_range(0, 7)) - 32'd3;  // many ties
			default: return $urandom();
		endcase
	endfunction

	task automatic send_run(int n);
		for (int i = 0; i < n; i++)
			send_request(rand_value(), i == n - 1);
	endtask

	// result side: random stalls before every result
	initial begin
		int gap;
		m_axis_tready = 0;
		@(posedge arst_n);
		forever begin
			gap = $urandom_range(0, 4);
			if (gap > 0) begin
				m_axis_tready <= 0;
				repeat (gap) @(posedge clk);
			end
			m_axis_tready <= 1;
			do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
			board.check_result(m_axis_tdata, m_axis_tlast, m_axis_tuser);
		end
	end

	initial begin
		int sent;
		int n;
		board = new();
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tlast = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: single element, extremes, ties, full store, overflow
		send_request(32'h8000_0000, 1);
		send_request(32'h7fff_ffff, 0);
		send_request(32'h8000_0000, 0);
		send_request(32'h0000_0000, 0);
		send_request(32'hffff_ffff, 0);
		send_request(32'h0000_0001, 1);
		send_request(32'd5, 0);
		send_request(32'd5, 0);
		send_request(32'd5, 1);
		// sender holds off until every result has drained
		drain();
		send_run(DEPTH);
		send_run(DEPTH + 3);  // dropped values incl. the closing one
		sent = 9 + 2 * DEPTH + 3;

		while (sent < 410) begin
			n = ($urandom_range(0, 9) == 0) ? $urandom_range(DEPTH - 1, DEPTH + 4)
			                                 : $urandom_range(1, 12);
			send_run(n);
			sent += n;
		end
		drain();
		repeat (50) @(posedge clk);
		if (fail_cnt == 0 && board.due.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin
		#20ms;
		$display("Test completed with failures");
		$finish;
	end
endmodule

### files.f
rtl/core/mse_pkg.sv
rtl/core/mse_front.sv
rtl/core/mse_back.sv
rtl/core/merge_sort_engine.sv
tb/merge_sort_engine_tb.sv
